>>> hw/rtl/ssll_pkg.sv
// Shared types and constants for the sorted slot linked list unit.
package ssll_pkg;

  localparam logic [7:0] NO_SLOT         = 8'hFF;
  localparam logic [7:0] MAX_VALUE_RESET = 8'd100;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SERR_NONE    = 2'd0,
    SERR_RANGE   = 2'd1,
    SERR_ON_LIST = 2'd2
  } slot_err_e;

  typedef enum logic [1:0] {
    VERR_NONE    = 2'd0,
    VERR_LIMIT   = 2'd1,
    VERR_PRESENT = 2'd2,
    VERR_MISSING = 2'd3
  } value_err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE,
    S_LINK_NODE,
    S_LINK_PREV,
    S_UNLINK,
    S_REPORT
  } state_e;

  // Write request into the node store.
  typedef struct packed {
    logic       val_we;
    logic       link_we;
    logic [7:0] addr;
    logic [7:0] val;
    logic [7:0] link;
  } ssll_wr_t;

  // Result of one command, shown for one cycle.
  typedef struct packed {
    logic       strobe;
    slot_err_e  slot_error;
    value_err_e value_error;
    logic       done;
    logic [7:0] head;
  } ssll_res_t;

endpackage

>>> hw/rtl/ssll_store.sv
// Node store: value and link memories with one write and one registered read port.
module ssll_store #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                          clk_i,
  input  ssll_pkg::ssll_wr_t            wr_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr_i,
  output logic [7:0]                    rd_val_o,
  output logic [7:0]                    rd_link_o
);
  import ssll_pkg::*;

  localparam int unsigned IW = $clog2(SLOT_COUNT);

  logic [7:0] val_mem  [SLOT_COUNT];
  logic [7:0] link_mem [SLOT_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      val_mem[wr_i.addr[IW-1:0]] <= wr_i.val;
    end
    if (wr_i.link_we) begin
      link_mem[wr_i.addr[IW-1:0]] <= wr_i.link;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_val_o  <= val_mem[rd_addr_i];
    rd_link_o <= link_mem[rd_addr_i];
  end

endmodule

>>> hw/rtl/ssll_core.sv
// Sequencer and walk datapath: one list node compared per cycle, then commit or reject.
module ssll_core #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          cmd_i,
  input  logic [7:0]                    slot_i,
  input  logic [7:0]                    value_i,
  input  logic [7:0]                    max_value_i,
  output logic                          busy_o,
  output ssll_pkg::ssll_wr_t            wr_o,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_addr_o,
  input  logic [7:0]                    rd_val_i,
  input  logic [7:0]                    rd_link_i,
  output ssll_pkg::ssll_res_t           res_o
);
  import ssll_pkg::*;

  localparam int unsigned IW        = $clog2(SLOT_COUNT);
  localparam int unsigned CW        = $clog2(SLOT_COUNT + 1);
  localparam logic [7:0]  SlotLimit = 8'(SLOT_COUNT);

  state_e     state_q, state_d;
  logic [7:0] head_q, head_d;

  cmd_e       cmd_q, cmd_d;
  logic [7:0] slot_q, slot_d;
  logic [7:0] value_q, value_d;
  logic [7:0] cur_q, cur_d;
  logic [7:0] prev_q, prev_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic       slot_hit_q, slot_hit_d;
  logic       found_q, found_d;
  logic [7:0] pos_pre_q, pos_pre_d;
  logic [7:0] pos_succ_q, pos_succ_d;
  logic [7:0] less_q, less_d;
  logic [7:0] less_succ_q, less_succ_d;
  slot_err_e  serr_q, serr_d;
  value_err_e verr_q, verr_d;
  logic       done_q, done_d;

  // Shared compare unit: node value against the command value.
  logic node_eq, node_lt;
  assign node_eq = (rd_val_i == value_q);
  assign node_lt = (rd_val_i < value_q);

  // Follow the link just read; at accept, read the head.
  assign rd_addr_o = (state_q == S_IDLE) ? head_q[IW-1:0] : rd_link_i[IW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    value_d     = value_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    slot_hit_d  = slot_hit_q;
    found_d     = found_q;
    pos_pre_d   = pos_pre_q;
    pos_succ_d  = pos_succ_q;
    less_d      = less_q;
    less_succ_d = less_succ_q;
    serr_d      = serr_q;
    verr_d      = verr_q;
    done_d      = done_q;
    wr_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d      = cmd_e'(cmd_i);
          slot_d     = slot_i;
          value_d    = value_i;
          cur_d      = head_q;
          prev_d     = NO_SLOT;
          cnt_d      = '0;
          slot_hit_d = 1'b0;
          found_d    = 1'b0;
          pos_pre_d  = NO_SLOT;
          pos_succ_d = NO_SLOT;
          less_d     = NO_SLOT;
          less_succ_d = NO_SLOT;
          state_d    = (head_q < SlotLimit) ? S_WALK : S_DECIDE;
        end
      end
      S_WALK: begin
        if (cur_q == slot_q) begin
          slot_hit_d = 1'b1;
        end
        if (node_eq && !found_q) begin
          found_d    = 1'b1;
          pos_pre_d  = prev_q;
          pos_succ_d = rd_link_i;
        end
        // List is sorted: the last smaller node is the insert point.
        if (node_lt) begin
          less_d      = cur_q;
          less_succ_d = rd_link_i;
        end
        prev_d = cur_q;
        cur_d  = rd_link_i;
        cnt_d  = cnt_q + CW'(1);
        if (!(rd_link_i < SlotLimit) || (cnt_q == CW'(SLOT_COUNT - 1))) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cmd_q == CMD_INSERT) begin
          if (!(slot_q < SlotLimit)) begin
            serr_d = SERR_RANGE;
          end else if (slot_hit_q) begin
            serr_d = SERR_ON_LIST;
          end else begin
            serr_d = SERR_NONE;
          end
          if (value_q > max_value_i) begin
            verr_d = VERR_LIMIT;
          end else if (found_q) begin
            verr_d = VERR_PRESENT;
          end else begin
            verr_d = VERR_NONE;
          end
          done_d  = (slot_q < SlotLimit) && !slot_hit_q &&
                    !(value_q > max_value_i) && !found_q;
          state_d = done_d ? S_LINK_NODE : S_REPORT;
        end else begin
          serr_d  = SERR_NONE;
          done_d  = !(value_q > max_value_i) && found_q;
          verr_d  = done_d ? VERR_NONE : VERR_MISSING;
          state_d = done_d ? S_UNLINK : S_REPORT;
        end
      end
      S_LINK_NODE: begin
        wr_o.val_we  = 1'b1;
        wr_o.link_we = 1'b1;
        wr_o.addr    = slot_q;
        wr_o.val     = value_q;
        wr_o.link    = (less_q < SlotLimit) ? less_succ_q : head_q;
        state_d      = S_LINK_PREV;
      end
      S_LINK_PREV: begin
        if (less_q < SlotLimit) begin
          wr_o.link_we = 1'b1;
          wr_o.addr    = less_q;
          wr_o.link    = slot_q;
        end else begin
          head_d = slot_q;
        end
        state_d = S_REPORT;
      end
      S_UNLINK: begin
        // Bypass the node; its slot is off the list and never read again.
        if (pos_pre_q < SlotLimit) begin
          wr_o.link_we = 1'b1;
          wr_o.addr    = pos_pre_q;
          wr_o.link    = pos_succ_q;
        end else begin
          head_d = pos_succ_q;
        end
        state_d = S_REPORT;
      end
      S_REPORT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NO_SLOT;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    slot_q      <= slot_d;
    value_q     <= value_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    cnt_q       <= cnt_d;
    slot_hit_q  <= slot_hit_d;
    found_q     <= found_d;
    pos_pre_q   <= pos_pre_d;
    pos_succ_q  <= pos_succ_d;
    less_q      <= less_d;
    less_succ_q <= less_succ_d;
    serr_q      <= serr_d;
    verr_q      <= verr_d;
    done_q      <= done_d;
  end

  assign busy_o = (state_q != S_IDLE);

  assign res_o.strobe      = (state_q == S_REPORT);
  assign res_o.slot_error  = serr_q;
  assign res_o.value_error = verr_q;
  assign res_o.done        = done_q;
  assign res_o.head        = head_q;

endmodule

>>> hw/rtl/sorted_slot_linked_list_unit.sv
// Top level of the sorted slot linked list unit.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------------------------
//  command   | in        | start, busy (taken: start&!busy) | cmd_i, slot_i, value_i
//  result    | out       | res_strobe_o, one cycle          | slot_error_o, value_error_o,
//            |           |                                  | done_res_o, head_slot_o
//  config    | in        | cfg_valid_i, cfg_ready_o         | cfg_wdata_i (max_value)
//
// Every command walks the list from the head, one node per cycle through a
// single registered read port of the node store, L nodes with L <= SLOT_COUNT.
// A decide state, then S_LINK_NODE and S_LINK_PREV (insert) or S_UNLINK (delete)
// if carried out, and a report state follow; the result strobe is the last busy
// cycle. The walk length, set by the store's one read port, dominates the command time.
// Reset empties the list at once (head register only) and sets max_value to
// 100; no clearing pass is needed since only linked slots are ever read.
// The receiver cannot stall: the result is shown for exactly one cycle.
module sorted_slot_linked_list_unit #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command
  input  logic       start,
  output logic       busy,
  input  logic       cmd_i,
  input  logic [7:0] slot_i,
  input  logic [7:0] value_i,
  // result
  output logic       res_strobe_o,
  output logic [1:0] slot_error_o,
  output logic [1:0] value_error_o,
  output logic       done_res_o,
  output logic [7:0] head_slot_o,
  // configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_wdata_i
);
  import ssll_pkg::*;

  logic [7:0] max_value_q;
  ssll_wr_t   wr;
  ssll_res_t  res;
  logic [$clog2(SLOT_COUNT)-1:0] rd_addr;
  logic [7:0] rd_val;
  logic [7:0] rd_link;

  // Take configuration only between commands so a walk sees a stable limit.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_value_q <= cfg_wdata_i;
    end
  end

  ssll_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .slot_i      (slot_i),
    .value_i     (value_i),
    .max_value_i (max_value_q),
    .busy_o      (busy),
    .wr_o        (wr),
    .rd_addr_o   (rd_addr),
    .rd_val_i    (rd_val),
    .rd_link_i   (rd_link),
    .res_o       (res)
  );

  ssll_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_val_o  (rd_val),
    .rd_link_o (rd_link)
  );

  // Drive the result transaction.
  assign res_strobe_o  = res.strobe;
  assign slot_error_o  = res.slot_error;
  assign value_error_o = res.value_error;
  assign done_res_o    = res.done;
  assign head_slot_o   = res.head;

endmodule

>>> hw/rtl/ssll_check.sv
// Port-level checker for the sorted slot linked list unit, bound to the top level.
module ssll_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       res_strobe_o,
  input logic [1:0] slot_error_o,
  input logic [1:0] value_error_o,
  input logic       done_res_o
);
  import ssll_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command transaction accepted without going busy");

  a_strobe_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy)
    else $error("result strobe outside a busy command");

  a_strobe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> (!busy && !res_strobe_o))
    else $error("unit stays busy after the result transaction");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && done_res_o) |->
      (slot_error_o == SERR_NONE && value_error_o == VERR_NONE))
    else $error("command carried out despite an error");

  a_reject_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !done_res_o) |->
      (slot_error_o != SERR_NONE || value_error_o != VERR_NONE))
    else $error("command rejected without an error code");

endmodule

bind sorted_slot_linked_list_unit ssll_check u_ssll_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .res_strobe_o  (res_strobe_o),
  .slot_error_o  (slot_error_o),
  .value_error_o (value_error_o),
  .done_res_o    (done_res_o)
);

>>> bench/tb.sv
// Self-checking bench for the sorted slot linked list unit: random and directed commands.
`timescale 1ns / 100ps

module tb;
  import ssll_pkg::*;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // One predicted command report.
  typedef struct {
    slot_err_e  serr;
    value_err_e verr;
    logic       done;
    logic [7:0] first;
  } list_report_t;

  // Shadow copy of the slot tables plus the queue of reports still owed by the block.
  class list_scoreboard;
    logic [7:0]   slot_val  [SLOTS];
    logic [7:0]   next_slot [SLOTS];
    logic [7:0]   first;
    logic [7:0]   limit;
    list_report_t owed_reports [$];
    int unsigned  reports_checked, mismatch_count;
    int unsigned  linked_count, unlinked_count, rejected_count, deepest;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_val[i]  = NO_SLOT;
        next_slot[i] = NO_SLOT;
      end
      first = NO_SLOT;
      limit = MAX_VALUE_RESET;
    endfunction

    function bit is_slot(int unsigned s);
      return s < SLOTS;
    endfunction

    // Walk from the head; a link that is no slot index ends the list.
    function bit slot_linked(int unsigned s);
      int unsigned cur;
      cur = 32'(first);
      for (int unsigned n = 0; n < SLOTS && is_slot(cur); n++) begin
        if (cur == s) return 1'b1;
        cur = 32'(next_slot[cur]);
      end
      return 1'b0;
    endfunction

    function bit find_holder(logic [7:0] v, output int unsigned pos, output int unsigned pre);
      int unsigned cur, prev;
      cur  = 32'(first);
      prev = 32'(NO_SLOT);
      pos  = 32'(NO_SLOT);
      pre  = 32'(NO_SLOT);
      for (int unsigned n = 0; n < SLOTS && is_slot(cur); n++) begin
        if (slot_val[cur] == v) begin
          pos = cur;
          pre = prev;
          return 1'b1;
        end
        prev = cur;
        cur  = 32'(next_slot[cur]);
      end
      return 1'b0;
    endfunction

    function void link_in(int unsigned s, logic [7:0] v);
      int unsigned prev, cur;
      slot_val[s] = v;
      if (!is_slot(first)) begin
        next_slot[s] = NO_SLOT;
        first = 8'(s);
        return;
      end
      if (v < slot_val[first]) begin
        next_slot[s] = first;
        first = 8'(s);
        return;
      end
      prev = 32'(first);
      cur  = 32'(next_slot[prev]);
      for (int unsigned n = 0; n < SLOTS && is_slot(cur) && v > slot_val[cur]; n++) begin
        prev = cur;
        cur  = 32'(next_slot[cur]);
      end
      next_slot[prev] = 8'(s);
      next_slot[s]    = is_slot(cur) ? 8'(cur) : NO_SLOT;
    endfunction

    function int unsigned list_length();
      int unsigned cur, n;
      cur = 32'(first);
      for (n = 0; n < SLOTS && is_slot(cur); n++) cur = 32'(next_slot[cur]);
      return n;
    endfunction

    // Predict the report of an accepted command and apply it to the shadow tables.
    function void note_command(cmd_e op, logic [7:0] slot, logic [7:0] value);
      list_report_t r;
      int unsigned  pos, pre;
      r.serr = SERR_NONE;
      r.verr = VERR_NONE;
      r.done = 1'b0;
      if (op == CMD_INSERT) begin
        if (!is_slot(slot)) r.serr = SERR_RANGE;
        else if (slot_linked(slot)) r.serr = SERR_ON_LIST;
        if (value > limit) r.verr = VERR_LIMIT;
        else if (find_holder(value, pos, pre)) r.verr = VERR_PRESENT;
        if (r.serr == SERR_NONE && r.verr == VERR_NONE) begin
          link_in(slot, value);
          r.done = 1'b1;
          linked_count++;
        end
      end else begin
        if (value <= limit && find_holder(value, pos, pre) && is_slot(pos)) begin
          if (!is_slot(pre)) first = next_slot[pos];
          else next_slot[pre] = next_slot[pos];
          slot_val[pos]  = NO_SLOT;
          next_slot[pos] = NO_SLOT;
          r.done = 1'b1;
          unlinked_count++;
        end else begin
          r.verr = VERR_MISSING;
        end
      end
      if (!r.done) rejected_count++;
      if (list_length() > deepest) deepest = list_length();
      r.first = first;
      owed_reports.push_back(r);
    endfunction

    function void note_limit(logic [7:0] v);
      limit = v;
    endfunction

    function void check_result(logic [1:0] serr, logic [1:0] verr, logic done,
                               logic [7:0] hd);
      list_report_t exp;
      if (owed_reports.size() == 0) begin
        $error("report strobe with no command outstanding");
        mismatch_count++;
        return;
      end
      exp = owed_reports.pop_front();
      reports_checked++;
      if (serr !== exp.serr) begin
        $error("slot_error: expected %0d, got %0d", exp.serr, serr);
        mismatch_count++;
      end
      if (verr !== exp.verr) begin
        $error("value_error: expected %0d, got %0d", exp.verr, verr);
        mismatch_count++;
      end
      if (done !== exp.done) begin
        $error("done_res: expected %0d, got %0d", exp.done, done);
        mismatch_count++;
      end
      if (hd !== exp.first) begin
        $error("head_slot: expected %0d, got %0d", exp.first, hd);
        mismatch_count++;
      end
    endfunction

    function void check_drained();
      if (owed_reports.size() != 0) begin
        $error("%0d reports never arrived", owed_reports.size());
        mismatch_count++;
      end
    endfunction

    function logic [7:0] listed_value();
      logic [7:0]  vals [$];
      int unsigned cur;
      cur = 32'(first);
      for (int unsigned n = 0; n < SLOTS && is_slot(cur); n++) begin
        vals.push_back(slot_val[cur]);
        cur = 32'(next_slot[cur]);
      end
      if (vals.size() == 0) return 8'($urandom_range(255));
      return vals[$urandom_range(vals.size() - 1)];
    endfunction

    function logic [7:0] pick_slot(bit want_linked);
      logic [7:0] picks [$];
      for (int i = 0; i < SLOTS; i++)
        if (slot_linked(i) == want_linked) picks.push_back(8'(i));
      if (picks.size() == 0) return 8'($urandom_range(SLOTS - 1));
      return picks[$urandom_range(picks.size() - 1)];
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       cmd_i       = 1'b0;
  logic [7:0] slot_i      = 8'd0;
  logic [7:0] value_i     = 8'd0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       busy, res_strobe_o, done_res_o, cfg_ready_o;
  logic [1:0] slot_error_o, value_error_o;
  logic [7:0] head_slot_o;

  list_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    issued = 0;
  int unsigned    settings = 0;

  sorted_slot_linked_list_unit #(.SLOT_COUNT(SLOTS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .slot_i        (slot_i),
    .value_i       (value_i),
    .res_strobe_o  (res_strobe_o),
    .slot_error_o  (slot_error_o),
    .value_error_o (value_error_o),
    .done_res_o    (done_res_o),
    .head_slot_o   (head_slot_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Monitor: check the report first, then predict any transaction taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe_o)
        sb.check_result(slot_error_o, value_error_o, done_res_o, head_slot_o);
      if (start && !busy)
        sb.note_command(cmd_e'(cmd_i), slot_i, value_i);
      if (cfg_valid_i && cfg_ready_o)
        sb.note_limit(cfg_wdata_i);
    end
  end

  // Present a command and hold it until the block takes it; start stays high
  // so a back-to-back command follows without a bubble.
  task automatic send_command(cmd_e op, logic [7:0] slot, logic [7:0] value);
    start   <= 1'b1;
    cmd_i   <= op;
    slot_i  <= slot;
    value_i <= value;
    do @(posedge clk_i); while (busy);
    issued++;
  endtask

  // Drop start for an idle stretch and scramble the idle payload.
  task automatic idle_for(int unsigned n);
    start   <= 1'b0;
    cmd_i   <= 1'($urandom_range(1));
    slot_i  <= 8'($urandom_range(255));
    value_i <= 8'($urandom_range(255));
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every outstanding report has come back, then let the block settle.
  task automatic settle();
    start <= 1'b0;
    while (sb.reports_checked != issued) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Mostly well-formed traffic: free slots for inserts, listed values for deletes.
  task automatic random_command(int unsigned insert_pct);
    cmd_e        op;
    logic [7:0]  slot, value;
    int unsigned r;
    op = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
    r  = $urandom_range(99);
    if (r < 82) slot = sb.pick_slot(1'b0);
    else if (r < 91) slot = sb.pick_slot(1'b1);
    else slot = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < ((op == CMD_DELETE) ? 60 : 12)) value = sb.listed_value();
    else if (r < 80) value = 8'($urandom_range(sb.limit));
    else if (r < 90) value = 8'($urandom_range(255));
    else begin
      case (r % 3)
        0: value = 8'd0;
        1: value = sb.limit;
        default: value = sb.limit + 8'd1;
      endcase
    end
    send_command(op, slot, value);
  endtask

  initial begin
    logic [7:0]  limits [8];
    int unsigned idle_pct;
    limits = '{8'd100, 8'd254, 8'd0, 8'd31, 8'd200, 8'd1, 8'd127, 8'd0};
    limits[7] = 8'($urandom_range(254));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty list, both error kinds at once, head/middle/tail inserts
    // and deletes, delete of a value over the limit, max_value raised to 254 and lowered to 0.
    send_command(CMD_DELETE, 8'd0,   8'd10);
    send_command(CMD_INSERT, 8'd32,  8'd101);
    send_command(CMD_INSERT, 8'd255, 8'd255);
    send_command(CMD_INSERT, 8'd0,   8'd50);
    send_command(CMD_INSERT, 8'd31,  8'd0);
    send_command(CMD_INSERT, 8'd5,   8'd100);
    send_command(CMD_INSERT, 8'd7,   8'd75);
    send_command(CMD_INSERT, 8'd5,   8'd60);
    send_command(CMD_INSERT, 8'd8,   8'd50);
    send_command(CMD_INSERT, 8'd0,   8'd50);
    send_command(CMD_INSERT, 8'd40,  8'd75);
    send_command(CMD_INSERT, 8'd7,   8'd101);
    send_command(CMD_DELETE, 8'd200, 8'd101);
    send_command(CMD_DELETE, 8'd0,   8'd75);
    send_command(CMD_DELETE, 8'd0,   8'd0);
    send_command(CMD_DELETE, 8'd0,   8'd100);
    send_command(CMD_DELETE, 8'd0,   8'd42);
    send_command(CMD_DELETE, 8'd0,   8'd50);
    send_command(CMD_INSERT, 8'd1,   8'd99);
    send_command(CMD_INSERT, 8'd2,   8'd98);
    write_limit(8'd254);
    send_command(CMD_INSERT, 8'd3,   8'd254);
    send_command(CMD_INSERT, 8'd4,   8'd255);
    send_command(CMD_INSERT, 8'd31,  8'd200);
    // Lowered limit: listed values stay but go out of reach.
    write_limit(8'd0);
    send_command(CMD_INSERT, 8'd6,   8'd0);
    send_command(CMD_INSERT, 8'd9,   8'd1);
    send_command(CMD_DELETE, 8'd0,   8'd99);
    send_command(CMD_INSERT, 8'd10,  8'd0);

    // Random phases, one per max_value setting; the last one runs without gaps.
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      for (int i = 0; i < 180; i++) begin
        if (i % 30 == 0) idle_pct = (p == 7) ? 0 : ((i / 30 + p) % 3) * 25;
        if ($urandom_range(99) < idle_pct) idle_for($urandom_range(6, 1));
        if (p != 7 && $urandom_range(99) < 2) settle();
        // Alternate filling and draining stretches so the list runs full and empty.
        random_command(((i / 45) % 2 == 0) ? 75 : 35);
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    sb.check_drained();
    $display("Ran %0d commands under %0d max_value settings: %0d linked, %0d unlinked,",
             issued, settings, sb.linked_count, sb.unlinked_count);
    $display("%0d rejected; longest list %0d of %0d slots.",
             sb.rejected_count, sb.deepest, SLOTS);
    if (sb.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
